FILE: rtl/fhss_hop_and_power_ramp_sequencer_top_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef FHSS_HOP_AND_POWER_RAMP_SEQUENCER_TOP_DEFINES_SVH
`define FHSS_HOP_AND_POWER_RAMP_SEQUENCER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FHSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fhss same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FHSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fhss next-cycle check failed");

`endif

FILE: rtl/fhss_pkg.sv
package fhss_pkg;

	localparam int CH_W   = 7;
	localparam int PWR_W  = 6;
	localparam int DIVD_W = 32;
	localparam int DIVS_W = 10;

	localparam logic [31:0] SHUFFLE_SEED = 32'hCAFEBABE;
	localparam logic signed [PWR_W-1:0] PWR_MIN = -6'sd9;
	localparam logic signed [PWR_W-1:0] PWR_MAX = 6'sd22;
	localparam logic [31:0] HOLD_SECONDS = 32'd10;
	localparam logic [31:0] POWER_GAP_MS = 32'd500;
	// Reciprocal of 1000 scaled by 2^38; the product's bits 63:38 give the exact
	// quotient for every 32-bit millisecond count.
	localparam logic [31:0] MS_RECIP = 32'd274877907;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_PKT   = 2'd2,
		OP_PWR   = 2'd3
	} op_t;

	localparam logic [2:0] CFG_NUM_CH   = 3'd0;
	localparam logic [2:0] CFG_SYNC_CH  = 3'd1;
	localparam logic [2:0] CFG_HOP_INT  = 3'd2;
	localparam logic [2:0] CFG_RAMP_S   = 3'd3;
	localparam logic [2:0] CFG_LCG_MUL  = 3'd4;
	localparam logic [2:0] CFG_LCG_INC  = 3'd5;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quot;
		logic [DIVS_W-1:0] rem;
	} div_resp_t;

endpackage

FILE: rtl/fhss_hop_and_power_ramp_sequencer_top.sv
// Stop, idle items and packet slots without a hop go straight to the output register.
// A hop with an empty table tunes to the sync channel; otherwise it divides the hop count by
// the channel count (unless that is zero) and tunes to sync or reads the next table entry.
// A power update divides only on a ramp slope. A start scans the channels into the table
// and, with two or more entries, shuffles it with one division per swap on the 32-step divider.
// One beat at a time: the next is taken the cycle after the result is registered.
// Reset is asynchronous and active low; it restores defaults and all state but the table and divider data.
`include "fhss_hop_and_power_ramp_sequencer_top_defines.svh"

module fhss_hop_and_power_ramp_sequencer_top #(
	parameter int MAX_CHANNELS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // time_ms[31:0]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// channel[6:0], power_dbm[12:7], ascending[13], packet_count[45:14],
	// hop_count[77:46], send_packet[78], retune[79], power_set[80],
	// cycle_restarted[81], running[82], zero fill[87:83]
	output logic [87:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);
	import fhss_pkg::*;

	localparam int AW = $clog2(MAX_CHANNELS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_FILL, ST_LCG, ST_MOD, ST_MODW, ST_RDI, ST_RDJ,
		ST_WRI, ST_WRJ, ST_TUNE0, ST_TUNE1, ST_HOPDIV, ST_HOPSEL, ST_HOPRD,
		ST_HOPWR, ST_EDIV, ST_PCLS, ST_RDIV, ST_OUT
	} state_t;

	state_t state_q;

	logic [6:0]  num_ch_q;
	logic [6:0]  sync_q;
	logic [7:0]  hop_int_q;
	logic [8:0]  ramp_q;
	logic [31:0] mul_q;
	logic [31:0] inc_q;

	op_t         op_q;
	logic [31:0] time_q;
	logic [7:0]  fill_i_q;
	logic [7:0]  len_q;
	logic [7:0]  sh_i_q;
	logic [AW-1:0] sh_j_q;
	logic [CH_W-1:0] ti_q;
	logic [31:0] rng_q;
	logic [AW-1:0] pos_q;
	logic [31:0] hops_q;
	logic [7:0]  poc_q;
	logic [31:0] pkts_q;
	logic [CH_W-1:0] tuned_q;
	logic signed [PWR_W-1:0] power_q;
	logic        rising_q;
	logic        active_q;
	logic [31:0] cs_ms_q;
	logic [31:0] last_ms_q;
	logic [31:0] e_q;
	logic        send_q;
	logic        retune_q;
	logic        pset_q;
	logic        rest_q;
	logic        m_tvalid_q;
	logic [87:0] m_tdata_q;
	div_req_t    div_req_q;
	div_resp_t   div_resp;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [CH_W-1:0] mem_wdata;
	logic [AW-1:0]   mem_raddr;
	logic [CH_W-1:0] mem_rdata;

	logic [7:0]  limit;
	logic [31:0] lcg_next;
	logic [31:0] ramp32;
	logic [31:0] e_minus;
	logic [13:0] e_x31;
	logic [13:0] d_x31;
	logic [7:0]  pos_inc;
	logic [31:0] hops_inc;
	logic [63:0] e_prod;

	assign limit = ({1'b0, num_ch_q} > 8'(MAX_CHANNELS)) ? 8'(MAX_CHANNELS) : {1'b0, num_ch_q};
	assign lcg_next = rng_q * mul_q + inc_q;
	assign ramp32 = {23'b0, ramp_q};
	assign e_minus = e_q - ramp32 - HOLD_SECONDS;
	assign e_x31 = {e_q[8:0], 5'b0} - {5'b0, e_q[8:0]};
	assign d_x31 = {e_minus[8:0], 5'b0} - {5'b0, e_minus[8:0]};
	assign pos_inc = {{(8-AW){1'b0}}, pos_q} + 8'd1;
	assign hops_inc = hops_q + 32'd1;
	assign e_prod = 64'(e_q) * 64'(MS_RECIP);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_i_q[AW-1:0];
		mem_wdata = fill_i_q[CH_W-1:0];
		mem_raddr = '0;
		unique case (state_q)
			ST_FILL: begin
				mem_we    = (fill_i_q != limit) && (fill_i_q != {1'b0, sync_q});
				mem_waddr = len_q[AW-1:0];
			end
			ST_RDI: mem_raddr = sh_i_q[AW-1:0];
			ST_RDJ: mem_raddr = sh_j_q;
			ST_WRI: begin
				mem_we    = 1'b1;
				mem_waddr = sh_i_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			ST_WRJ: begin
				mem_we    = 1'b1;
				mem_waddr = sh_j_q;
				mem_wdata = ti_q;
			end
			ST_HOPRD: mem_raddr = pos_q;
			default: begin
			end
		endcase
	end

	fhss_table #(.DEPTH(MAX_CHANNELS), .AW(AW)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fhss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.resp   (div_resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q  <= 7'd40;
			sync_q    <= 7'd20;
			hop_int_q <= 8'd4;
			ramp_q    <= 9'd60;
			mul_q     <= 32'd214013;
			inc_q     <= 32'd2531011;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_NUM_CH:  num_ch_q  <= cfg_data[6:0];
				CFG_SYNC_CH: sync_q    <= cfg_data[6:0];
				CFG_HOP_INT: hop_int_q <= cfg_data[7:0];
				CFG_RAMP_S:  ramp_q    <= cfg_data[8:0];
				CFG_LCG_MUL: mul_q     <= cfg_data;
				CFG_LCG_INC: inc_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_STOP;
			time_q     <= '0;
			fill_i_q   <= '0;
			len_q      <= '0;
			sh_i_q     <= '0;
			sh_j_q     <= '0;
			ti_q       <= '0;
			rng_q      <= '0;
			pos_q      <= '0;
			hops_q     <= '0;
			poc_q      <= '0;
			pkts_q     <= '0;
			tuned_q    <= '0;
			power_q    <= PWR_MIN;
			rising_q   <= 1'b1;
			active_q   <= 1'b0;
			cs_ms_q    <= '0;
			last_ms_q  <= '0;
			e_q        <= '0;
			send_q     <= 1'b0;
			retune_q   <= 1'b0;
			pset_q     <= 1'b0;
			rest_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			div_req_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q     <= op_t'(s_tuser);
						time_q   <= s_tdata;
						send_q   <= 1'b0;
						retune_q <= 1'b0;
						pset_q   <= 1'b0;
						rest_q   <= 1'b0;
						state_q  <= ST_DISP;
					end
				end
				ST_DISP: begin
					unique case (op_q)
						OP_START: begin
							fill_i_q <= '0;
							len_q    <= '0;
							state_q  <= ST_FILL;
						end
						OP_STOP: begin
							active_q <= 1'b0;
							state_q  <= ST_OUT;
						end
						OP_PKT: begin
							if (active_q) begin
								send_q <= 1'b1;
								pkts_q <= pkts_q + 32'd1;
								if (poc_q >= hop_int_q) begin
									poc_q    <= 8'd1;
									hops_q   <= hops_inc;
									retune_q <= 1'b1;
									if (len_q == 8'd0) begin
										tuned_q <= sync_q;
										state_q <= ST_OUT;
									end else if (num_ch_q != 7'd0) begin
										div_req_q <= '{start: 1'b1, dividend: hops_inc,
											divisor: {3'b0, num_ch_q}};
										state_q <= ST_HOPDIV;
									end else begin
										state_q <= ST_HOPSEL;
									end
								end else begin
									if (poc_q != 8'hFF) begin
										poc_q <= poc_q + 8'd1;
									end
									state_q <= ST_OUT;
								end
							end else begin
								state_q <= ST_OUT;
							end
						end
						OP_PWR: begin
							if (active_q && ((time_q - last_ms_q) >= POWER_GAP_MS)) begin
								last_ms_q <= time_q;
								pset_q    <= 1'b1;
								e_q       <= time_q - cs_ms_q;
								state_q   <= ST_EDIV;
							end else begin
								state_q <= ST_OUT;
							end
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_FILL: begin
					if (fill_i_q == limit) begin
						if (len_q < 8'd2) begin
							state_q <= ST_TUNE0;
						end else begin
							sh_i_q  <= len_q - 8'd1;
							rng_q   <= SHUFFLE_SEED;
							state_q <= ST_LCG;
						end
					end else begin
						if (fill_i_q != {1'b0, sync_q}) begin
							len_q <= len_q + 8'd1;
						end
						fill_i_q <= fill_i_q + 8'd1;
					end
				end
				ST_LCG: begin
					rng_q   <= lcg_next;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					div_req_q <= '{start: 1'b1, dividend: {16'b0, rng_q[31:16]},
						divisor: {2'b0, sh_i_q + 8'd1}};
					state_q <= ST_MODW;
				end
				ST_MODW: begin
					div_req_q.start <= 1'b0;
					if (div_resp.done) begin
						sh_j_q  <= div_resp.rem[AW-1:0];
						state_q <= ST_RDI;
					end
				end
				ST_RDI: state_q <= ST_RDJ;
				ST_RDJ: begin
					ti_q    <= mem_rdata;
					state_q <= ST_WRI;
				end
				ST_WRI: state_q <= ST_WRJ;
				ST_WRJ: begin
					if (sh_i_q == 8'd1) begin
						state_q <= ST_TUNE0;
					end else begin
						sh_i_q  <= sh_i_q - 8'd1;
						state_q <= ST_LCG;
					end
				end
				ST_TUNE0: state_q <= ST_TUNE1;
				ST_TUNE1: begin
					tuned_q   <= (len_q != 8'd0) ? mem_rdata : sync_q;
					pos_q     <= '0;
					hops_q    <= '0;
					poc_q     <= '0;
					power_q   <= PWR_MIN;
					rising_q  <= 1'b1;
					cs_ms_q   <= time_q;
					last_ms_q <= time_q;
					active_q  <= 1'b1;
					pkts_q    <= 32'd1;
					send_q    <= 1'b1;
					retune_q  <= 1'b1;
					pset_q    <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_HOPDIV: begin
					div_req_q.start <= 1'b0;
					if (div_resp.done) begin
						if (div_resp.rem == '0) begin
							tuned_q <= sync_q;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_HOPSEL;
						end
					end
				end
				ST_HOPSEL: begin
					pos_q   <= (pos_inc == len_q) ? '0 : pos_inc[AW-1:0];
					state_q <= ST_HOPRD;
				end
				ST_HOPRD: state_q <= ST_HOPWR;
				ST_HOPWR: begin
					tuned_q <= mem_rdata;
					state_q <= ST_OUT;
				end
				ST_EDIV: begin
					e_q     <= {6'b0, e_prod[63:38]};
					state_q <= ST_PCLS;
				end
				ST_PCLS: begin
					if (e_q >= (ramp32 + ramp32 + HOLD_SECONDS)) begin
						cs_ms_q  <= time_q;
						power_q  <= PWR_MIN;
						rising_q <= 1'b1;
						rest_q   <= 1'b1;
						state_q  <= ST_OUT;
					end else if (e_q < ramp32) begin
						rising_q  <= 1'b1;
						div_req_q <= '{start: 1'b1, dividend: {18'b0, e_x31},
							divisor: {1'b0, ramp_q}};
						state_q   <= ST_RDIV;
					end else if (e_q < (ramp32 + HOLD_SECONDS)) begin
						power_q  <= PWR_MAX;
						rising_q <= 1'b1;
						state_q  <= ST_OUT;
					end else begin
						rising_q  <= 1'b0;
						div_req_q <= '{start: 1'b1, dividend: {18'b0, d_x31},
							divisor: {1'b0, ramp_q}};
						state_q   <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					div_req_q.start <= 1'b0;
					if (div_resp.done) begin
						power_q <= rising_q ? (PWR_MIN + PWR_W'(div_resp.quot[4:0]))
							: (PWR_MAX - PWR_W'(div_resp.quot[4:0]));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'b0, active_q, rest_q, pset_q, retune_q, send_q,
							hops_q, pkts_q, rising_q, power_q, tuned_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FHSS_ASSERT_IMP(a_wr_range, mem_we, 32'(mem_waddr) < 32'(MAX_CHANNELS))
	`FHSS_ASSERT_IMP(a_div_free, div_req_q.start, !div_resp.busy)
	`FHSS_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

FILE: rtl/fhss_div.sv
module fhss_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fhss_pkg::div_req_t  req,
	output fhss_pkg::div_resp_t resp
);
	import fhss_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVD_W-1:0] dvd_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   trial;
	logic              ge;
	logic [DIVS_W:0]   nrem;

	assign trial = {rem_q, dvd_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign nrem  = ge ? (trial - {1'b0, dvs_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVD_W-2:0], ge};
			rem_q <= nrem[DIVS_W-1:0];
		end
	end

	assign resp.busy = busy_q;
	assign resp.done = done_q;
	assign resp.quot = dvd_q;
	assign resp.rem  = rem_q;

endmodule

FILE: rtl/fhss_table.sv
module fhss_table #(
	parameter int DEPTH = 80,
	parameter int AW    = 7
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [fhss_pkg::CH_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [fhss_pkg::CH_W-1:0] rdata
);
	import fhss_pkg::*;

	logic [CH_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
